[sv/bdlp_pkg.sv]
// Shared types, sizes and helpers for the button debounce / long-press queue.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps

package bdlp_pkg;

    localparam int BUTTON_COUNT = 3;
    localparam int RING_DEPTH   = 8;
    localparam int RING_AW      = $clog2(RING_DEPTH);
    localparam int CNT_W        = $clog2(RING_DEPTH + 1);

    localparam int TIME_W   = 32;
    localparam int MS_W     = 16;
    localparam int BTN_W    = 2;
    localparam int CFG_IDX_W = 1;

    // tdata layouts, padded to whole bytes
    localparam int IN_FIELDS_W  = TIME_W + BUTTON_COUNT;
    localparam int IN_DATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = 1 + BTN_W + 1;
    localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS = 1'd1;

    localparam logic [MS_W-1:0] DEBOUNCE_RESET   = 16'd30;
    localparam logic [MS_W-1:0] LONG_PRESS_RESET = 16'd800;

    typedef struct packed {
        logic valid;
        logic is_long;
    } lane_evt_t;

    typedef struct packed {
        logic [BTN_W-1:0] button;
        logic             is_long;
    } ring_entry_t;

    typedef struct packed {
        logic             valid;
        logic [BTN_W-1:0] button;
        logic             is_long;
    } result_t;

    function automatic logic [RING_AW-1:0] ring_inc(input logic [RING_AW-1:0] h);
        ring_inc = (h == RING_AW'(RING_DEPTH - 1)) ? '0 : h + 1'b1;
    endfunction

    function automatic logic [RING_AW-1:0] ring_add(input logic [RING_AW-1:0] h,
                                                    input logic [CNT_W-1:0]   c);
        logic [RING_AW:0] sum;
        sum = (RING_AW + 1)'(h) + (RING_AW + 1)'(c);
        if (sum >= (RING_AW + 1)'(RING_DEPTH))
            sum = sum - (RING_AW + 1)'(RING_DEPTH);
        ring_add = sum[RING_AW-1:0];
    endfunction

endpackage

[sv/bdlp_lane.sv]
// One button lane: debounce timer, stable state and long-press tracking.
// Depends on bdlp_pkg; produces at most one event per poll.
`timescale 1ns / 1ps

module bdlp_lane (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          step,
    input  logic [bdlp_pkg::TIME_W-1:0]   now_ms,
    input  logic                          raw,
    input  logic [bdlp_pkg::MS_W-1:0]     debounce_ms,
    input  logic [bdlp_pkg::MS_W-1:0]     long_press_ms,
    output bdlp_pkg::lane_evt_t           evt
);
    import bdlp_pkg::*;

    logic              stable_reg;
    logic              last_raw_reg;
    logic [TIME_W-1:0] edge_time_reg;
    logic [TIME_W-1:0] down_since_reg;
    logic              long_fired_reg;

    logic              level_change;
    logic [TIME_W-1:0] since_edge;
    logic [TIME_W-1:0] since_down;
    logic              settled;
    logic              go_stable;
    logic              go_down;
    logic              stable_eff;
    logic              fired_eff;
    logic              held_long;
    logic              short_evt;
    logic              long_evt;

    // Both elapsed times come from registered state; a change this poll means zero elapsed.
    always_comb
    begin
        level_change = (raw != last_raw_reg);
        since_edge   = now_ms - edge_time_reg;
        since_down   = now_ms - down_since_reg;
        settled      = level_change ? (debounce_ms == '0)
                                    : (since_edge >= TIME_W'(debounce_ms));
        go_stable    = (raw != stable_reg) && settled;
        go_down      = go_stable && raw;
        stable_eff   = go_stable ? raw : stable_reg;
        fired_eff    = go_down ? 1'b0 : long_fired_reg;
        held_long    = go_down ? (long_press_ms == '0)
                               : (since_down >= TIME_W'(long_press_ms));
        short_evt    = go_stable && !raw && !long_fired_reg;
        long_evt     = stable_eff && !fired_eff && held_long;
        evt.valid    = short_evt || long_evt;
        evt.is_long  = long_evt;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stable_reg     <= 1'b0;
            last_raw_reg   <= 1'b0;
            edge_time_reg  <= '0;
            down_since_reg <= '0;
            long_fired_reg <= 1'b0;
        end
        else if (step)
        begin
            last_raw_reg <= raw;
            if (level_change)
                edge_time_reg <= now_ms;
            if (go_stable)
                stable_reg <= raw;
            if (go_down)
                down_since_reg <= now_ms;
            if (long_evt)
                long_fired_reg <= 1'b1;
            else if (go_down)
                long_fired_reg <= 1'b0;
        end
    end

endmodule

[sv/bdlp_ring.sv]
// Merge stage: pushes the lane events in button order into the event ring,
// dropping the oldest entry when full, then pops at most one. Uses bdlp_pkg.
`timescale 1ns / 1ps

module bdlp_ring (
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  logic                                          step,
    input  bdlp_pkg::lane_evt_t [bdlp_pkg::BUTTON_COUNT-1:0] events,
    output bdlp_pkg::result_t                             result
);
    import bdlp_pkg::*;

    ring_entry_t             ring_reg [RING_DEPTH];
    ring_entry_t             ring_next [RING_DEPTH];
    logic [RING_AW-1:0]      head_reg;
    logic [RING_AW-1:0]      head_next;
    logic [CNT_W-1:0]        count_reg;
    logic [CNT_W-1:0]        count_next;

    always_comb
    begin
        logic [RING_AW-1:0] h;
        logic [CNT_W-1:0]   c;
        logic [RING_AW-1:0] slot;
        h = head_reg;
        c = count_reg;
        slot = '0;
        for (int k = 0; k < RING_DEPTH; k++)
            ring_next[k] = ring_reg[k];
        for (int i = 0; i < BUTTON_COUNT; i++)
        begin
            if (events[i].valid)
            begin
                // drop oldest when full
                if (c == CNT_W'(RING_DEPTH))
                begin
                    h = ring_inc(h);
                    c = CNT_W'(RING_DEPTH - 1);
                end
                slot = ring_add(h, c);
                ring_next[slot].button  = BTN_W'(i);
                ring_next[slot].is_long = events[i].is_long;
                c = c + 1'b1;
            end
        end
        if (c != '0)
        begin
            result.valid   = 1'b1;
            result.button  = ring_next[h].button;
            result.is_long = ring_next[h].is_long;
            h = ring_inc(h);
            c = c - 1'b1;
        end
        else
        begin
            result = '0;
        end
        head_next  = h;
        count_next = c;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            count_reg <= '0;
        end
        else if (step)
        begin
            head_reg  <= head_next;
            count_reg <= count_next;
        end
    end

    // Entries are only read once counted, so they need no reset.
    always_ff @(posedge clk)
    begin
        if (step)
        begin
            for (int k = 0; k < RING_DEPTH; k++)
                ring_reg[k] <= ring_next[k];
        end
    end

endmodule

[sv/bdlp_out_stage.sv]
// Output register with a skid entry so input ready is a registered signal.
// Uses bdlp_pkg::result_t.
`timescale 1ns / 1ps

module bdlp_out_stage (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  bdlp_pkg::result_t in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output bdlp_pkg::result_t out_data
);
    import bdlp_pkg::*;

    logic    out_valid_reg;
    logic    skid_valid_reg;
    result_t out_data_reg;
    result_t skid_data_reg;
    logic    in_xfer;
    logic    out_free;

    assign in_ready  = !skid_valid_reg;
    assign in_xfer   = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= in_xfer;
            end
        end
        else if (in_xfer)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            if (skid_valid_reg)
                out_data_reg <= skid_data_reg;
            else if (in_xfer)
                out_data_reg <= in_data;
        end
        else if (in_xfer)
        begin
            skid_data_reg <= in_data;
        end
    end

endmodule

[sv/button_debounce_long_press_queue_unit.sv]
// Top level of the button debouncer with long-press detection and event ring.
// Depends on bdlp_pkg, bdlp_lane, bdlp_ring and bdlp_out_stage.
`timescale 1ns / 1ps

// Usage:
//   Slave stream s_axis carries one poll per transfer: tdata holds now_ms
//   (bits 31:0) and pressed_raw (bits 34:32, one bit per button).
//   Master stream m_axis returns exactly one result per poll: tdata holds
//   event_valid (bit 0), event_button (bits 2:1) and event_long (bit 3).
//   Config channel cfg_* writes debounce_ms (index 0) and long_press_ms
//   (index 1); it is always ready and should be used while the block is idle.
// Timing:
//   A poll is taken every cycle while s_axis_tready is high. Its result is
//   registered in the output stage before it is on m_axis. All three button
//   lanes and the ring push/pop run in the transfer cycle; the per-lane
//   32-bit elapsed-time compares and the three-deep ring merge set the cycle.
// Reset:
//   rst_n clears all button state, empties the ring and restores the register
//   defaults (30 ms debounce, 800 ms long press).
// Stall:
//   When m_axis_tready is low the result is held and one more poll lands in a
//   skid entry; s_axis_tready then drops until the held result is taken.
module button_debounce_long_press_queue_unit (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // now_ms[31:0], pressed_raw[34:32], zero pad
    input  logic [bdlp_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // event_valid[0], event_button[2:1], event_long[3], zero pad
    output logic [bdlp_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [bdlp_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [bdlp_pkg::MS_W-1:0]        cfg_data
);
    import bdlp_pkg::*;

    logic [MS_W-1:0]                 debounce_reg;
    logic [MS_W-1:0]                 long_press_reg;
    logic                            step;
    logic [TIME_W-1:0]               now_ms;
    logic [BUTTON_COUNT-1:0]         pressed_raw;
    lane_evt_t [BUTTON_COUNT-1:0]    events;
    result_t                         result;
    result_t                         out_result;

    assign cfg_ready   = 1'b1;
    assign step        = s_axis_tvalid && s_axis_tready;
    assign now_ms      = s_axis_tdata[TIME_W-1:0];
    assign pressed_raw = s_axis_tdata[TIME_W +: BUTTON_COUNT];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_reg   <= DEBOUNCE_RESET;
            long_press_reg <= LONG_PRESS_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_DEBOUNCE:   debounce_reg   <= cfg_data;
                REG_LONG_PRESS: long_press_reg <= cfg_data;
                default:        ;
            endcase
        end
    end

    for (genvar g = 0; g < BUTTON_COUNT; g++)
    begin : g_lane
        bdlp_lane u_lane (
            .clk           (clk),
            .rst_n         (rst_n),
            .step          (step),
            .now_ms        (now_ms),
            .raw           (pressed_raw[g]),
            .debounce_ms   (debounce_reg),
            .long_press_ms (long_press_reg),
            .evt           (events[g])
        );
    end

    bdlp_ring u_ring (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .events (events),
        .result (result)
    );

    bdlp_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_data   (result),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (out_result)
    );

    assign m_axis_tdata = OUT_DATA_W'({out_result.is_long, out_result.button,
                                       out_result.valid});

    // Every accepted poll leaves a result waiting on the master side.
    a_poll_yields_result: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> m_axis_tvalid)
        else $error("accepted poll produced no pending result");

    // A dequeued event always names an existing button.
    a_button_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[0] |-> m_axis_tdata[2:1] < BTN_W'(BUTTON_COUNT))
        else $error("event names a button that does not exist");

    // An empty result carries no button or kind.
    a_empty_result_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[3:1] == 3'b000)
        else $error("empty result carries event fields");

endmodule
